@@ rtl/nps_pkg.sv @@
package nps_pkg;

	localparam int MAX_RANK   = 8;
	localparam int DIGIT_BITS = 4;
	localparam int ORDER_BITS = 32;
	localparam int SLOTS      = ORDER_BITS / DIGIT_BITS;
	localparam int VALS       = 1 << DIGIT_BITS;
	localparam int RANK_CAP   = (MAX_RANK < SLOTS) ? MAX_RANK : SLOTS;
	localparam int RANK_BITS  = 4;
	localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [ORDER_BITS-1:0] order_t;
	typedef logic [DIGIT_BITS-1:0] digit_t;
	typedef logic [DIGIT_BITS:0]   bound_t;
	typedef logic [VALS-1:0]       used_t;
	typedef logic [RANK_BITS-1:0]  rank_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEARCH,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic   found;
		digit_t value;
	} scan_res_t;

	function automatic digit_t get_digit(input order_t o, input idx_t i);
		return o[int'(i) * DIGIT_BITS +: DIGIT_BITS];
	endfunction

	function automatic order_t put_digit(input order_t o, input idx_t i, input digit_t v);
		order_t r;
		r = o;
		r[int'(i) * DIGIT_BITS +: DIGIT_BITS] = v;
		return r;
	endfunction

	function automatic used_t val_bit(input digit_t v);
		return used_t'(1) << v;
	endfunction

	// Identity ordering: digits below rank hold their own position, others zero.
	function automatic order_t identity(input rank_t r);
		order_t o;
		o = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (i < int'(r))
				o[i * DIGIT_BITS +: DIGIT_BITS] = digit_t'(i);
		end
		return o;
	endfunction

endpackage

@@ rtl/nps_free_scan.sv @@
// Lowest value at or above lo and below lim that is not yet in the used set.
module nps_free_scan (
	input  nps_pkg::used_t     used,
	input  nps_pkg::bound_t    lo,
	input  nps_pkg::rank_t     lim,
	output nps_pkg::scan_res_t res
);
	import nps_pkg::*;

	used_t cand;

	always_comb begin
		for (int v = 0; v < VALS; v++) begin
			cand[v] = !used[v] && (bound_t'(v) >= lo) && (bound_t'(v) < bound_t'(lim));
		end
	end

	always_comb begin
		res = '0;
		for (int v = VALS - 1; v >= 0; v--) begin
			if (cand[v]) begin
				res.found = 1'b1;
				res.value = digit_t'(v);
			end
		end
	end

endmodule

@@ rtl/next_permutation_stepper_core.sv @@
// Next-permutation stepper.
// Holds an ordering of up to eight indices, one 4-bit digit each, digit 0 in
// bits 3:0 and most significant in lexicographic order. The rank register is
// written through cfg_we / cfg_wdata by the user, only while the block is idle;
// the block does not enforce this. Input channel (in_valid / in_ready): one
// beat carries start_over. A beat with start_over set loads the identity
// ordering; a clear one steps to the next ordering in lexicographic order.
// Past the last ordering the block returns to identity and flags exhausted.
// Output channel (out_valid / out_ready): one beat per input beat, carrying
// the new ordering and the exhausted flag.
// At rank zero an advance leaves the ordering unchanged. An advance walks the
// shared free-value scan unit over the digits: it scans for the first
// repeated digit, searches for a digit to bump, refills the tail and posts.
// A restart or rank zero goes straight to posting.
// One beat is in flight at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the next input beat is already taken and worked on.
// Reset clears the ordering and the rank to zero and empties the output.
module next_permutation_stepper_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  nps_pkg::rank_t      cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                start_over,
	output logic                out_valid,
	input  logic                out_ready,
	output nps_pkg::order_t     ordering,
	output logic                exhausted
);
	import nps_pkg::*;

	state_t    state_q, state_d;
	rank_t     rank_q;
	rank_t     r_eff;
	order_t    order_q, order_d;
	used_t     used_q, used_d;
	idx_t      idx_q, idx_d;
	logic      exh_q, exh_d;
	order_t    res_order_q;
	logic      res_exh_q;
	logic      out_valid_q;
	logic      in_acc;
	logic      post;
	logic      last;
	digit_t    cur_digit;
	digit_t    prev_digit;
	bound_t    scan_lo;
	scan_res_t scan;

	assign r_eff      = (rank_q > rank_t'(RANK_CAP)) ? rank_t'(RANK_CAP) : rank_q;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign post       = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign last       = (rank_t'(idx_q) + rank_t'(1)) == r_eff;
	assign cur_digit  = get_digit(order_q, idx_q);
	assign prev_digit = get_digit(order_q, idx_q - idx_t'(1));

	// Search bumps the current digit; fill takes the lowest free value.
	assign scan_lo = (state_q == ST_SEARCH) ? (bound_t'(cur_digit) + bound_t'(1)) : '0;

	nps_free_scan u_scan (
		.used (used_q),
		.lo   (scan_lo),
		.lim  (r_eff),
		.res  (scan)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (start_over || r_eff == '0)
						state_d = ST_DONE;
					else
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// stop at the first repeated digit or at the last one
				if (used_q[cur_digit] || last)
					state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (scan.found)
					state_d = last ? ST_DONE : ST_FILL;
				else if (idx_q == '0)
					state_d = ST_DONE;
			end
			ST_FILL: begin
				if (last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers.
	always_comb begin
		order_d = order_q;
		used_d  = used_q;
		idx_d   = idx_q;
		exh_d   = exh_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					exh_d  = 1'b0;
					used_d = '0;
					idx_d  = '0;
					if (start_over)
						order_d = identity(r_eff);
				end
			end
			ST_SCAN: begin
				// on exit, used holds the distinct prefix below idx
				if (!used_q[cur_digit] && !last) begin
					used_d = used_q | val_bit(cur_digit);
					idx_d  = idx_q + idx_t'(1);
				end
			end
			ST_SEARCH: begin
				if (scan.found) begin
					order_d = put_digit(order_q, idx_q, scan.value);
					used_d  = used_q | val_bit(scan.value);
					idx_d   = idx_q + idx_t'(1);
				end else if (idx_q == '0) begin
					order_d = identity(r_eff);
					exh_d   = 1'b1;
				end else begin
					// drop the digit left of this one from the prefix set
					used_d = used_q & ~val_bit(prev_digit);
					idx_d  = idx_q - idx_t'(1);
				end
			end
			ST_FILL: begin
				order_d = put_digit(order_q, idx_q, scan.value);
				used_d  = used_q | val_bit(scan.value);
				idx_d   = idx_q + idx_t'(1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rank_q      <= '0;
			order_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			order_q <= order_d;
			if (cfg_we)
				rank_q <= cfg_wdata;
			if (post)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		used_q <= used_d;
		idx_q  <= idx_d;
		exh_q  <= exh_d;
		if (post) begin
			res_order_q <= order_q;
			res_exh_q   <= exh_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ordering  = res_order_q;
	assign exhausted = res_exh_q;

endmodule

@@ rtl/nps_checker.sv @@
module nps_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_we,
	input nps_pkg::rank_t  cfg_wdata,
	input logic            in_valid,
	input logic            in_ready,
	input logic            start_over,
	input logic            out_valid,
	input logic            out_ready,
	input nps_pkg::order_t ordering,
	input logic            exhausted
);
	import nps_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ordering) && $stable(exhausted))
		else $error("stalled result changed");

	// One beat in flight: busy right after an accept.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A wrap returns to identity, so the leading digits read 0 and 1 (or 0).
	a_wrap_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exhausted |-> ordering[3:0] == 4'd0 &&
			(ordering[7:4] == 4'd0 || ordering[7:4] == 4'd1))
		else $error("exhausted result is not identity");

	// A result appears only after the input side has gone busy.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result with no item in flight");

	logic unused_in;
	assign unused_in = cfg_we ^ (|cfg_wdata) ^ start_over;

endmodule

bind next_permutation_stepper_core nps_checker u_nps_checker (.*);

@@ verif/next_permutation_stepper_core_tb.sv @@
`timescale 1ns / 100ps

// Drives restart and advance beats into the permutation stepper, predicts every
// ordering in a behavioral model kept alongside the block, and checks each
// output beat field by field. Rank is rewritten between phases while the block
// sits idle, so leftover orderings from one rank feed the next one.
module next_permutation_stepper_core_tb;
	import nps_pkg::*;

	localparam bit RESTART = 1'b1;
	localparam bit ADVANCE = 1'b0;

	localparam int TARGET_ITEMS    = 1900;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_BEAT   = 600;
	// Drain time after the last beat, scaled from the capped rank.
	localparam int DRAIN_CYCLES    = 3 * RANK_CAP + 8;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef struct packed {
		order_t ord;
		logic   wrapped;
	} step_result_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   cfg_we     = 1'b0;
	rank_t  cfg_wdata  = '0;
	logic   in_valid   = 1'b0;
	logic   in_ready;
	logic   start_over = 1'b0;
	logic   out_valid;
	logic   out_ready  = 1'b0;
	order_t ordering;
	logic   exhausted;

	// Pending beats for the driver, and the orderings they must produce.
	bit           step_reqs[$];
	step_result_t expected_steps[$];

	// Shadow of the block's state, updated as each input beat is taken.
	order_t model_order = '0;
	rank_t  model_rank  = '0;

	int  send_gap      = 0;
	int  recv_gap      = 0;
	bit  send_calm     = 1'b0;
	bit  recv_calm     = 1'b0;
	bit  held_off      = 1'b0;
	int  quiet_cycles  = 0;
	int  fails         = 0;
	int  items_queued  = 0;
	int  beats_checked = 0;
	int  restarts      = 0;
	int  advances      = 0;
	int  wraps         = 0;
	int  rank_writes   = 0;
	logic [15:0] ranks_seen = '0;

	next_permutation_stepper_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_over (start_over),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ordering   (ordering),
		.exhausted  (exhausted)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Identity for rank r: each digit below r holds its own position, the rest 0.
	function automatic order_t home_order(input int r);
		order_t o;
		o = '0;
		for (int i = 0; i < r; i++)
			o[i*DIGIT_BITS +: DIGIT_BITS] = digit_t'(i);
		return o;
	endfunction

	// Next ordering in lexicographic order, digit 0 most significant. Walk the
	// bump position from the least significant digit upward; a position only
	// qualifies if the digits ahead of it are distinct and a larger unused value
	// below rank exists. Refill the tail with the smallest unused values.
	function automatic order_t advance_order(input order_t cur, input rank_t rk,
			input bit restart, output bit wrapped);
		order_t          o;
		logic [VALS-1:0] taken;
		int              r, p, v, u;
		bit              dup, hit;
		o       = cur;
		wrapped = 1'b0;
		// Saturate rank to what the digit slots and the cap allow.
		r = int'(rk);
		if (r > RANK_CAP)
			r = RANK_CAP;
		if (restart) begin
			o = home_order(r);
		end else if (r > 0) begin
			hit = 1'b0;
			p   = r;
			while (p > 0 && !hit) begin
				p--;
				taken = '0;
				dup   = 1'b0;
				// Out-of-range digits count as distinct values here.
				for (int q = 0; q < p; q++) begin
					if (taken[o[q*DIGIT_BITS +: DIGIT_BITS]])
						dup = 1'b1;
					taken[o[q*DIGIT_BITS +: DIGIT_BITS]] = 1'b1;
				end
				if (!dup) begin
					v = int'(o[p*DIGIT_BITS +: DIGIT_BITS]) + 1;
					while (v < r && taken[v])
						v++;
					if (v < r) begin
						o[p*DIGIT_BITS +: DIGIT_BITS] = digit_t'(v);
						taken[v] = 1'b1;
						for (int q = p + 1; q < r; q++) begin
							u = 0;
							while (u < r && taken[u])
								u++;
							taken[u] = 1'b1;
							o[q*DIGIT_BITS +: DIGIT_BITS] = digit_t'(u);
						end
						hit = 1'b1;
					end
				end
			end
			// Ran off the last ordering: fall back to identity and flag it.
			if (!hit) begin
				o       = home_order(r);
				wrapped = 1'b1;
			end
		end
		return o;
	endfunction

	// Mostly short gaps, now and then a long one; none at all in calm stretches.
	function automatic int pick_gap(input bit calm);
		int roll;
		roll = $urandom_range(99);
		if (calm || roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Input side: take the next request from the queue, hold it until the beat
	// is taken, then predict its ordering and drop valid for the chosen gap.
	always @(posedge clk or negedge arst_n) begin : driver
		bit           offer;
		int           hold;
		bit           wrapped;
		step_result_t res;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			start_over <= 1'b0;
			send_gap   <= 0;
		end else begin
			offer = in_valid;
			hold  = send_gap;
			if (in_valid && in_ready) begin
				model_order = advance_order(model_order, model_rank, start_over, wrapped);
				res.ord     = model_order;
				res.wrapped = wrapped;
				expected_steps.push_back(res);
				if (start_over == RESTART)
					restarts++;
				else
					advances++;
				if (wrapped)
					wraps++;
				offer = 1'b0;
				hold  = pick_gap(send_calm);
			end
			if (!offer) begin
				if (hold > 0) begin
					hold--;
				end else if (step_reqs.size() != 0) begin
					offer = 1'b1;
					start_over <= step_reqs.pop_front();
				end
			end
			in_valid <= offer;
			send_gap <= hold;
		end
	end

	// Output side: check every beat against the oldest prediction and stall
	// ready at random. Once, mid-run, hold off long enough that the block's
	// output register and its in-flight slot both fill and it stops taking input.
	always @(posedge clk or negedge arst_n) begin : monitor
		step_result_t want;
		int           stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			stall = recv_gap;
			if (out_valid && out_ready) begin
				beats_checked++;
				if (expected_steps.size() == 0) begin
					$error("unexpected beat: ordering %h exhausted %b", ordering, exhausted);
					fails++;
				end else begin
					want = expected_steps.pop_front();
					if (ordering !== want.ord) begin
						$error("ordering: expected %h, got %h", want.ord, ordering);
						fails++;
					end
					if (exhausted !== want.wrapped) begin
						$error("exhausted: expected %b, got %b", want.wrapped, exhausted);
						fails++;
					end
				end
				stall = pick_gap(recv_calm);
				if (!held_off && beats_checked >= HOLD_OFF_BEAT && step_reqs.size() > 8) begin
					held_off = 1'b1;
					stall    = HOLD_OFF_CYCLES;
				end
			end else if (stall == 0 && !recv_calm && $urandom_range(99) < 3) begin
				// Drop ready now and then even with nothing on offer.
				stall = $urandom_range(1, 4);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			recv_gap <= stall;
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_step(input bit kind);
		step_reqs.push_back(kind);
		items_queued++;
	endtask

	// Hold the sender until every queued beat is sent and every result is back.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (step_reqs.size() != 0 || in_valid || expected_steps.size() != 0);
	endtask

	// Drain, then write rank for one cycle; the shadow copy follows the write.
	task automatic set_rank(input rank_t rk);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rk;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_rank     = rk;
		ranks_seen[rk] = 1'b1;
		rank_writes++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int    n;
		int    roll;
		rank_t rk;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Rank zero out of reset: advance leaves the ordering alone, restart gives 0.
		queue_step(ADVANCE);
		queue_step(RESTART);

		// Rank 3: walk from identity up to 2,0,1.
		set_rank(4'd3);
		queue_step(RESTART);
		repeat (4) queue_step(ADVANCE);

		// Lower to 2 with an out-of-range leading digit and a kept upper digit,
		// then advance past the end so the block wraps.
		set_rank(4'd2);
		repeat (2) queue_step(ADVANCE);

		// Raise to 4 over 0,1,0,0: the repeated leading digits force a carry.
		set_rank(4'd4);
		repeat (2) queue_step(ADVANCE);

		// Ranks above the cap saturate.
		set_rank(4'd15);
		queue_step(RESTART);
		repeat (2) queue_step(ADVANCE);
		set_rank(4'd9);
		queue_step(RESTART);
		queue_step(ADVANCE);

		// Rank 1 has a single ordering, so every advance wraps.
		set_rank(4'd1);
		repeat (2) queue_step(ADVANCE);

		// Random phases: mostly long advance runs at one rank, with occasional
		// restarts. Skip the restart at phase start half the time so the
		// previous rank's ordering carries over into the new one.
		while (items_queued < TARGET_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 10)
				rk = rank_t'($urandom_range(9, 15));
			else if (roll < 30)
				rk = rank_t'(RANK_CAP);
			else if (roll < 34)
				rk = '0;
			else
				rk = rank_t'($urandom_range(1, 7));
			set_rank(rk);
			send_calm = ($urandom_range(3) == 0);
			recv_calm = ($urandom_range(3) == 0);
			if ($urandom_range(1) == 1)
				queue_step(RESTART);
			n = $urandom_range(20, 120);
			repeat (n)
				queue_step(($urandom_range(99) < 5) ? RESTART : ADVANCE);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d restarts and %0d advances, %0d of them wrapping to identity.",
			restarts, advances, wraps);
		$display("Rank written %0d times, values seen %b, long output hold-off %s.",
			rank_writes, ranks_seen, held_off ? "applied" : "not reached");
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
